### src/ntc_pkg.sv
package ntc_pkg;

	// widths of the datapath
	localparam int CODE_W   = 12;
	localparam int X_W      = 17;   // divider leg value, 1..65536
	localparam int LOG_FRAC = 24;
	localparam int MANT_W   = 31;   // mantissa in [1,2) with 30 fraction bits
	localparam int MANT_FRAC = 30;
	localparam int LOG_W    = 29;   // exponent (5 bits) plus 24 fraction bits
	localparam int BETA_W   = 16;
	localparam int REF_W    = 10;
	localparam int PROD_W   = 61;   // |d| times ln 2
	localparam int LN_W     = 29;
	localparam int RK_W     = REF_W + LN_W;
	localparam int DEN_W    = 41;
	localparam int REM_W    = 61;
	localparam int KEL_W    = 20;
	localparam int CEL_W    = 21;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;

	localparam int ADC_FULL_SCALE_DEF = 4096;

	localparam logic [31:0] LN2_Q32 = 32'd2977044472;
	localparam logic [KEL_W-1:0] KELVIN_MAX = '1;
	localparam logic [CEL_W-1:0] ZERO_C_Q8 = 21'd69888;

	localparam logic [BETA_W-1:0] BETA_RST = 16'd3435;
	localparam logic [REF_W-1:0]  REF_RST  = 10'd298;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BETA = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REF  = 2'd1;

	// status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_ZERO = 2'd1;
	localparam logic [1:0] ST_SAT  = 2'd2;

	typedef struct packed {
		logic zero;
		logic cold;
		logic hot;
	} flags_t;

	typedef struct packed {
		logic [MANT_W-1:0] m;
		logic [LOG_W-1:0]  acc;
	} log_lane_t;

	typedef struct packed {
		flags_t    f;
		log_lane_t num;
		log_lane_t code;
	} log_pair_t;

	typedef struct packed {
		flags_t            f;
		logic [DEN_W-1:0]  den;
		logic [REM_W-1:0]  rem;
		logic [KEL_W-1:0]  q;
	} div_word_t;

	// integer part of log2 and normalized mantissa
	function automatic log_lane_t log_norm(input logic [X_W-1:0] x);
		log_lane_t       r;
		logic [4:0]      e;
		logic [X_W+MANT_FRAC-1:0] w;
		e = '0;
		for (int i = 0; i < X_W; i++) begin
			if (x[i])
				e = 5'(i);
		end
		w = {{MANT_FRAC{1'b0}}, x} << (5'(MANT_FRAC) - e);
		r.m = w[MANT_W-1:0];
		r.acc = {e, {LOG_FRAC{1'b0}}};
		return r;
	endfunction

endpackage

### src/ntc_log_cell.sv
module ntc_log_cell #(
	parameter int BIT = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  ntc_pkg::log_pair_t in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output ntc_pkg::log_pair_t out_data
);
	import ntc_pkg::*;

	logic                valid_q;
	log_pair_t           data_q;
	log_pair_t           nxt;
	logic [2*MANT_W-1:0] sq_num;
	logic [2*MANT_W-1:0] sq_code;
	logic [MANT_W:0]     t_num;
	logic [MANT_W:0]     t_code;

	assign in_ready = !valid_q || out_ready;

	// one squaring step per lane, one result bit each
	always_comb begin
		nxt = in_data;
		sq_num = in_data.num.m * in_data.num.m;
		sq_code = in_data.code.m * in_data.code.m;
		t_num = sq_num[2*MANT_W-1:MANT_FRAC];
		t_code = sq_code[2*MANT_W-1:MANT_FRAC];
		if (t_num[MANT_W]) begin
			nxt.num.m = t_num[MANT_W:1];
			nxt.num.acc[BIT] = 1'b1;
		end else begin
			nxt.num.m = t_num[MANT_W-1:0];
		end
		if (t_code[MANT_W]) begin
			nxt.code.m = t_code[MANT_W:1];
			nxt.code.acc[BIT] = 1'b1;
		end else begin
			nxt.code.m = t_code[MANT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (in_ready)
			valid_q <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			data_q <= nxt;
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

### src/ntc_div_cell.sv
module ntc_div_cell #(
	parameter int BIT = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  ntc_pkg::div_word_t in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output ntc_pkg::div_word_t out_data
);
	import ntc_pkg::*;

	logic             valid_q;
	div_word_t        data_q;
	div_word_t        nxt;
	logic [REM_W-1:0] sub;

	assign in_ready = !valid_q || out_ready;

	// restoring step: one quotient bit
	always_comb begin
		nxt = in_data;
		sub = {{(REM_W-DEN_W){1'b0}}, in_data.den} << BIT;
		if (in_data.rem >= sub) begin
			nxt.rem = in_data.rem - sub;
			nxt.q[BIT] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (in_ready)
			valid_q <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			data_q <= nxt;
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

### src/ntc_adc_to_temperature_top.sv
// ntc thermistor converter: one adc code in, one temperature out
// input channel: in_valid/in_ready with adc_code (12 bits unsigned)
// output channel: out_valid/out_ready with kelvin_q8 (unsigned, 8 fraction
//   bits), celsius_q8 (signed, 8 fraction bits) and status
//   (0 ok, 1 code zero, 2 saturated)
// config channel: cfg_valid/cfg_ready, cfg_index 0 = beta, 1 = ref_kelvin;
//   cfg_ready is always high, other indexes are dropped; write only when idle
// latency: 51 cycles from input transaction to output valid
//   (normalize 1, log2 cells 24, ln/denominator/numerator 5, divide cells 20,
//   output register 1)
// throughput: one transaction per cycle; every stage is a cell with its own
//   valid bit, so bubbles close up and a new code is taken while a finished
//   result waits at the output
// receiver stall: the output register holds, cells fill up behind it and
//   in_ready drops only when every stage holds a transaction
// reset: all stage valid bits clear, beta returns to 3435, ref_kelvin to 298
module ntc_adc_to_temperature_top #(
	parameter int ADC_FULL_SCALE = ntc_pkg::ADC_FULL_SCALE_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [ntc_pkg::CODE_W-1:0]      adc_code,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [ntc_pkg::KEL_W-1:0]       kelvin_q8,
	output logic signed [ntc_pkg::CEL_W-1:0] celsius_q8,
	output logic [1:0]                      status,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [ntc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ntc_pkg::CFG_DAT_W-1:0]   cfg_data
);
	import ntc_pkg::*;

	localparam logic [X_W:0] FULL = (X_W+1)'(ADC_FULL_SCALE);
	localparam int NLOG = LOG_FRAC;
	localparam int NDIV = KEL_W;

	// configuration registers
	logic [BETA_W-1:0] beta_q;
	logic [REF_W-1:0]  ref_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beta_q <= BETA_RST;
			ref_q  <= REF_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_BETA: beta_q <= cfg_data[BETA_W-1:0];
				REG_REF:  ref_q  <= cfg_data[REF_W-1:0];
				default:  ;
			endcase
		end
	end

	// stage 1: flags and normalization of both divider legs
	logic      vld_s1, rdy_s1;
	log_pair_t dat_s1;
	log_pair_t norm;
	logic [X_W:0] code_x;
	logic [X_W:0] num_x;

	always_comb begin
		code_x = {{(X_W+1-CODE_W){1'b0}}, adc_code};
		num_x = FULL - code_x;
		norm.f.zero = (adc_code == '0);
		norm.f.cold = (code_x >= FULL);
		norm.f.hot  = 1'b0;
		norm.num  = log_norm(num_x[X_W-1:0]);
		norm.code = log_norm(code_x[X_W-1:0]);
	end

	// log2 cell chain, bit 23 first
	logic      lv [NLOG+1];
	logic      lr [NLOG+1];
	log_pair_t ld [NLOG+1];

	assign in_ready = rdy_s1;
	assign rdy_s1 = !vld_s1 || lr[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (rdy_s1)
			vld_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid)
			dat_s1 <= norm;
	end

	assign lv[0] = vld_s1;
	assign ld[0] = dat_s1;

	for (genvar g = 0; g < NLOG; g++) begin : g_log
		ntc_log_cell #(.BIT(NLOG-1-g)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (lv[g]),
			.in_ready (lr[g]),
			.in_data  (ld[g]),
			.out_valid(lv[g+1]),
			.out_ready(lr[g+1]),
			.out_data (ld[g+1])
		);
	end

	// stage 2: log difference times ln 2
	logic               vld_s2, rdy_s2;
	flags_t             f_s2;
	logic               neg_s2;
	logic [PROD_W-1:0]  prod_s2;
	logic signed [LOG_W:0] dlog;
	logic [LOG_W:0]     dmag;

	assign lr[NLOG] = rdy_s2;

	always_comb begin
		dlog = signed'({1'b0, ld[NLOG].num.acc}) - signed'({1'b0, ld[NLOG].code.acc});
		dmag = dlog[LOG_W] ? (LOG_W+1)'(-dlog) : dlog;
	end

	// stage 3: round to ln, scale by reference temperature
	logic              vld_s3, rdy_s3;
	flags_t            f_s3;
	logic              neg_s3;
	logic [RK_W-1:0]   rk_s3;
	logic [PROD_W-1:0] prod_rnd;

	assign rdy_s2 = !vld_s2 || rdy_s3;
	assign prod_rnd = prod_s2 + PROD_W'(64'd1 << 31);

	// stage 4: denominator beta*2^24 - ref*ln
	logic              vld_s4, rdy_s4;
	flags_t            f_s4;
	logic [DEN_W-1:0]  den_s4;
	logic [DEN_W:0]    bs;

	assign rdy_s3 = !vld_s3 || rdy_s4;
	assign bs = {{(DEN_W+1-BETA_W-LOG_FRAC){1'b0}}, beta_q, {LOG_FRAC{1'b0}}};

	// stage 5: rounded numerator
	logic              vld_s5, rdy_s5;
	flags_t            f_s5;
	logic [DEN_W-1:0]  den_s5;
	logic [REM_W-1:0]  nn_s5;
	logic [BETA_W+REF_W-1:0] rb;

	assign rdy_s4 = !vld_s4 || rdy_s5;
	assign rb = ref_q * beta_q;

	// stage 6: overflow check against 2^20 times the denominator
	logic              vld_s6, rdy_s6;
	div_word_t         dat_s6;

	assign rdy_s5 = !vld_s5 || rdy_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (rdy_s2)
				vld_s2 <= lv[NLOG];
			if (rdy_s3)
				vld_s3 <= vld_s2;
			if (rdy_s4)
				vld_s4 <= vld_s3;
			if (rdy_s5)
				vld_s5 <= vld_s4;
			if (rdy_s6)
				vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && lv[NLOG]) begin
			f_s2    <= ld[NLOG].f;
			neg_s2  <= dlog[LOG_W];
			prod_s2 <= dmag[LOG_W-1:0] * LN2_Q32;
		end
		if (rdy_s3 && vld_s2) begin
			f_s3   <= f_s2;
			neg_s3 <= neg_s2;
			rk_s3  <= ref_q * prod_rnd[PROD_W-1:32];
		end
		if (rdy_s4 && vld_s3) begin
			// positive ln lowers the denominator, it can reach zero
			f_s4 <= '{zero: f_s3.zero, cold: f_s3.cold,
				hot: !neg_s3 && ({{(DEN_W+1-RK_W){1'b0}}, rk_s3} >= bs)};
			den_s4 <= neg_s3 ? DEN_W'(bs + (DEN_W+1)'(rk_s3))
			                 : DEN_W'(bs - (DEN_W+1)'(rk_s3));
		end
		if (rdy_s5 && vld_s4) begin
			f_s5   <= f_s4;
			den_s5 <= den_s4;
			nn_s5  <= {{(REM_W-BETA_W-REF_W-32){1'b0}}, rb, 32'd0}
			          + {{(REM_W-DEN_W+1){1'b0}}, den_s4[DEN_W-1:1]};
		end
		if (rdy_s6 && vld_s5) begin
			dat_s6 <= '{f: '{zero: f_s5.zero, cold: f_s5.cold,
					hot: f_s5.hot || (nn_s5 >= {den_s5, {KEL_W{1'b0}}})},
				den: den_s5, rem: nn_s5, q: '0};
		end
	end

	// divider cell chain, quotient bit 19 first
	logic      dv [NDIV+1];
	logic      dr [NDIV+1];
	div_word_t dd [NDIV+1];

	assign dv[0]  = vld_s6;
	assign dd[0]  = dat_s6;
	assign rdy_s6 = !vld_s6 || dr[0];

	for (genvar g = 0; g < NDIV; g++) begin : g_div
		ntc_div_cell #(.BIT(NDIV-1-g)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (dv[g]),
			.in_ready (dr[g]),
			.in_data  (dd[g]),
			.out_valid(dv[g+1]),
			.out_ready(dr[g+1]),
			.out_data (dd[g+1])
		);
	end

	// output register with saturation and status
	logic             out_vld_q;
	logic [KEL_W-1:0] kel_q;
	logic [CEL_W-1:0] cel_q;
	logic [1:0]       st_q;
	logic [KEL_W-1:0] kel_nxt;
	logic [CEL_W-1:0] cel_nxt;
	logic [1:0]       st_nxt;

	assign dr[NDIV] = !out_vld_q || out_ready;

	always_comb begin
		priority if (dd[NDIV].f.zero) begin
			kel_nxt = '0;
			st_nxt  = ST_ZERO;
		end else if (dd[NDIV].f.cold) begin
			kel_nxt = '0;
			st_nxt  = ST_SAT;
		end else if (dd[NDIV].f.hot) begin
			kel_nxt = KELVIN_MAX;
			st_nxt  = ST_SAT;
		end else begin
			kel_nxt = dd[NDIV].q;
			st_nxt  = ST_OK;
		end
		cel_nxt = dd[NDIV].f.zero ? '0 : ({1'b0, kel_nxt} - ZERO_C_Q8);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (dr[NDIV])
			out_vld_q <= dv[NDIV];
	end

	always_ff @(posedge clk) begin
		if (dr[NDIV] && dv[NDIV]) begin
			kel_q <= kel_nxt;
			cel_q <= cel_nxt;
			st_q  <= st_nxt;
		end
	end

	assign out_valid  = out_vld_q;
	assign kelvin_q8  = kel_q;
	assign celsius_q8 = signed'(cel_q);
	assign status     = st_q;

	// a code of zero always reports zero temperatures
	a_zero_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_ZERO |-> kelvin_q8 == '0 && celsius_q8 == '0)
		else $error("zero code gave nonzero temperature");

	// celsius follows kelvin for every non-zero-code transaction
	a_cel_kel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_ZERO |->
			cel_q == ({1'b0, kelvin_q8} - ZERO_C_Q8))
		else $error("celsius and kelvin disagree");

	// input side stalls only when the output is blocked
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output backpressure");

	// status never carries an undefined code
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == ST_OK || status == ST_ZERO || status == ST_SAT)
		else $error("bad status code");

endmodule

### test/ntc_temp_checker.sv
`timescale 1ns / 100ps

module ntc_temp_checker
	import ntc_pkg::*;
#(
	parameter int FULL_SCALE = ADC_FULL_SCALE_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic                     in_ready,
	input  logic [CODE_W-1:0]        adc_code,
	input  logic                     out_valid,
	input  logic                     out_ready,
	input  logic [KEL_W-1:0]         kelvin_q8,
	input  logic signed [CEL_W-1:0]  celsius_q8,
	input  logic [1:0]               status,
	input  logic                     cfg_valid,
	input  logic                     cfg_ready,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DAT_W-1:0]     cfg_data,
	output int                       errors,
	output int                       pending,
	output int                       checked
);

	typedef struct {
		logic [KEL_W-1:0] kel;
		logic [CEL_W-1:0] cel;
		logic [1:0]       st;
	} temp_t;

	temp_t temps_due[$];
	logic [BETA_W-1:0] beta_r;
	logic [REF_W-1:0]  t0_r;

	// log2 with 24 fraction bits by repeated squaring
	function automatic logic [63:0] log2_q24(input logic [63:0] x);
		logic [63:0] e, m, acc;
		e = 0;
		while (e < 16 && (x >> (e + 1)) != 0)
			e++;
		m = x << (MANT_FRAC - e);
		acc = e << LOG_FRAC;
		for (int i = LOG_FRAC - 1; i >= 0; i--) begin
			m = (m * m) >> MANT_FRAC;
			if (m >= (64'd2 << MANT_FRAC)) begin
				m = m >> 1;
				acc[i] = 1'b1;
			end
		end
		return acc;
	endfunction

	function automatic temp_t make_temp(input logic [KEL_W-1:0] k, input logic [1:0] s);
		temp_t t;
		t.kel = k;
		t.cel = CEL_W'(longint'(k) - 69888);
		t.st = s;
		return t;
	endfunction

	function automatic temp_t beta_temp(input logic [CODE_W-1:0] code);
		temp_t t;
		longint d, ln, den;
		logic [63:0] mag, num, q;
		if (code == 0) begin
			t.kel = '0;
			t.cel = '0;
			t.st = ST_ZERO;
			return t;
		end
		if (code >= FULL_SCALE)
			return make_temp('0, ST_SAT);
		d = longint'(log2_q24(FULL_SCALE - code)) - longint'(log2_q24(64'(code)));
		mag = (d < 0) ? -d : d;
		mag = (mag * 64'd2977044472 + (64'd1 << 31)) >> 32;
		ln = (d < 0) ? -longint'(mag) : longint'(mag);
		den = (longint'(beta_r) <<< LOG_FRAC) - longint'(t0_r) * ln;
		if (den <= 0)
			return make_temp(KELVIN_MAX, ST_SAT);
		num = (64'(t0_r) * 64'(beta_r)) << 32;
		q = (num + (64'(den) >> 1)) / 64'(den);
		if (q > 64'(KELVIN_MAX))
			return make_temp(KELVIN_MAX, ST_SAT);
		return make_temp(q[KEL_W-1:0], ST_OK);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		temp_t want;
		if (!arst_n) begin
			beta_r = BETA_RST;
			t0_r = REF_RST;
			temps_due.delete();
			errors = 0;
			checked = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_BETA)
					beta_r = cfg_data;
				else if (cfg_index == REG_REF)
					t0_r = cfg_data[REF_W-1:0];
			end
			if (out_valid && out_ready) begin
				if (temps_due.size() == 0) begin
					$error("result with no code outstanding");
					errors++;
				end else begin
					want = temps_due.pop_front();
					checked++;
					if (kelvin_q8 !== want.kel) begin
						$error("kelvin_q8 expected %0d got %0d", want.kel, kelvin_q8);
						errors++;
					end
					if (celsius_q8 !== want.cel) begin
						$error("celsius_q8 expected %0d got %0d",
							$signed(want.cel), celsius_q8);
						errors++;
					end
					if (status !== want.st) begin
						$error("status expected %0d got %0d", want.st, status);
						errors++;
					end
				end
			end
			if (in_valid && in_ready)
				temps_due.push_back(beta_temp(adc_code));
		end
		pending = temps_due.size();
	end

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import ntc_pkg::*;

	localparam int LATENCY = 51;
	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [CODE_W-1:0] adc_code = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [KEL_W-1:0] kelvin_q8;
	logic signed [CEL_W-1:0] celsius_q8;
	logic [1:0] status;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data = '0;

	int errors, pending, checked;
	int cycles = 0;
	int codes_sent = 0;
	int settings_run = 0;

	// idle control: sender gaps and receiver stalls, 68 in a hundred when
	// only one side idles, 32 in a hundred when both do
	bit send_gaps = 0;
	bit recv_stalls = 0;
	bit hold_go = 0;
	int idle_pct = 68;

	always #6 clk = ~clk;

	ntc_adc_to_temperature_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .adc_code(adc_code),
		.out_valid(out_valid), .out_ready(out_ready),
		.kelvin_q8(kelvin_q8), .celsius_q8(celsius_q8), .status(status),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	ntc_temp_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .adc_code(adc_code),
		.out_valid(out_valid), .out_ready(out_ready),
		.kelvin_q8(kelvin_q8), .celsius_q8(celsius_q8), .status(status),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .pending(pending), .checked(checked)
	);

	// watchdog on total run length
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("CHECK FAILED");
			$finish;
		end
	end

	// receiver: random stalls, plus one long hold-off so the pipe fills up
	always @(negedge clk) begin
		static int hold_left = 0;
		static bit hold_done = 0;
		if (hold_go && !hold_done) begin
			hold_left = 4 * LATENCY;
			hold_done = 1;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (recv_stalls)
			out_ready <= ($urandom_range(99) >= idle_pct);
		else
			out_ready <= 1'b1;
	end

	// one code transaction; called and returning at a falling edge
	task automatic send_code(input logic [CODE_W-1:0] code);
		int gap;
		gap = 0;
		if (send_gaps)
			while ($urandom_range(99) < idle_pct)
				gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		adc_code <= code;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		codes_sent++;
	endtask

	// wait until every outstanding result is back and the pipe is empty
	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (LATENCY + 10) @(negedge clk);
	endtask

	// register write transaction, only while idle
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// mostly uniform codes, with shares near both ends of the scale and near midscale
	function automatic logic [CODE_W-1:0] pick_code();
		case ($urandom_range(9))
			0: return CODE_W'($urandom_range(8));
			1: return CODE_W'(4095 - $urandom_range(8));
			2: return CODE_W'($urandom_range(2100, 2000));
			default: return CODE_W'($urandom);
		endcase
	endfunction

	task automatic random_phase(input int n);
		for (int i = 0; i < n; i++) begin
			// rotate the idle pattern so gaps land on every pipeline phase
			send_gaps = (i / 19) % 4 inside {1, 3};
			recv_stalls = (i / 19) % 4 inside {2, 3};
			idle_pct = ((i / 19) % 4 == 3) ? 32 : 68;
			send_code(pick_code());
		end
		send_gaps = 0;
		recv_stalls = 0;
		idle_pct = 68;
	endtask

	task automatic set_regs(input logic [CFG_DAT_W-1:0] b, input logic [CFG_DAT_W-1:0] t0);
		drain();
		write_reg(REG_BETA, b);
		write_reg(REG_REF, t0);
		settings_run++;
	endtask

	initial begin
		static logic [CODE_W-1:0] directed[$] = '{0, 1, 2, 4095, 4094, 2048, 2047, 1024,
			3072, 12'h555, 12'haaa, 100, 3900};
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset defaults: extremes, midscale, alternating bit patterns
		foreach (directed[i])
			send_code(directed[i]);
		settings_run++;
		random_phase(60);

		// writes to unused indexes must leave the registers alone
		drain();
		write_reg(2'd2, 16'hffff);
		write_reg(2'd3, 16'h0001);
		foreach (directed[i])
			send_code(directed[i]);

		// largest beta and reference; upper data bits of ref are dropped
		set_regs(16'hffff, 16'hffff);
		random_phase(60);

		// tiny beta: denominator goes non-positive on the hot side
		set_regs(16'd1, 16'd1);
		foreach (directed[i])
			send_code(directed[i]);
		random_phase(40);

		// zero registers, outside the nominal range
		set_regs(16'd0, 16'd0);
		random_phase(30);

		// large reference against nominal beta: overflow past 20 bits
		set_regs(16'd3435, 16'd1023);
		random_phase(60);

		// long receiver hold-off while codes keep coming
		hold_go = 1;
		for (int i = 0; i < 80; i++)
			send_code(pick_code());

		// random settings for the rest
		for (int s = 0; s < 3; s++) begin
			set_regs(CFG_DAT_W'($urandom_range(65535, 1)), CFG_DAT_W'($urandom_range(1023, 1)));
			random_phase(30);
		end

		drain();
		$display("sent %0d adc codes over %0d register settings, %0d results compared",
			codes_sent, settings_run, checked);
		$display("covered code zero, both scale ends, saturation, stalls and a full pipe");
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
